// ===== hw/rtl/qudit_pair_gate_engine_unit_assert.svh =====
// Assertion macros for the qudit pair gate engine.
// Included inside module bodies that declare clk and rst_n.
`ifndef QUDIT_PAIR_GATE_ENGINE_UNIT_ASSERT_SVH
`define QUDIT_PAIR_GATE_ENGINE_UNIT_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define QPGE_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qpge assertion failed");

// Condition must never be true outside reset.
`define QPGE_NEVER(lbl, cond) `QPGE_CHECK(lbl, !(cond))

`endif

// ===== hw/rtl/qpge_pkg.sv =====
// Shared types and constants of the qudit pair gate engine.
// No dependencies; used by the interfaces, the MAC datapath and the top level.
package qpge_pkg;

  localparam int AMP_W  = 16;
  localparam int COEF_W = 17;
  localparam int PROD_W = 33;
  localparam int ACC_W  = 40;
  localparam int IDX_W  = 6;
  localparam int OP_W   = 3;

  localparam longint ONE28 = 64'sd1 << 28;
  localparam longint PI28  = 64'sd843314857;

  typedef enum logic [OP_W-1:0] {
    OP_WR_AMP = 3'd0,
    OP_WR_UNI = 3'd1,
    OP_APPLY  = 3'd2,
    OP_DFT    = 3'd3,
    OP_IDFT   = 3'd4,
    OP_CZ     = 3'd5,
    OP_RD_AMP = 3'd6
  } op_t;

  typedef struct packed {
    logic             vld;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] dst;
  } mac_ctl_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [AMP_W-1:0] re;
    logic [AMP_W-1:0] im;
    logic             sat;
  } amp_wr_t;

endpackage

// ===== hw/rtl/qpge_if.sv =====
// Valid/ready channel interfaces for the qudit pair gate engine.
// Depends on qpge_pkg for field widths.
interface qpge_in_if;
  import qpge_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [IDX_W-1:0]        index;
  logic                    side;
  logic signed [AMP_W-1:0] value_re;
  logic signed [AMP_W-1:0] value_im;
  modport source(output valid, operation, index, side, value_re, value_im, input ready);
  modport sink(input valid, operation, index, side, value_re, value_im, output ready);
endinterface

interface qpge_out_if;
  import qpge_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [AMP_W-1:0] amp_re;
  logic signed [AMP_W-1:0] amp_im;
  logic                    saturated;
  modport source(output valid, amp_re, amp_im, saturated, input ready);
  modport sink(input valid, amp_re, amp_im, saturated, output ready);
endinterface

// ===== hw/rtl/qpge_cmac.sv =====
// Complex multiply-accumulate datapath: product stage, accumulate stage,
// round/saturate to Q1.15 on the last term. Depends on qpge_pkg.
module qpge_cmac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  qpge_pkg::mac_ctl_t                ctl_i,
  input  logic signed [qpge_pkg::AMP_W-1:0]  smp_re_i,
  input  logic signed [qpge_pkg::AMP_W-1:0]  smp_im_i,
  input  logic signed [qpge_pkg::COEF_W-1:0] coef_re_i,
  input  logic signed [qpge_pkg::COEF_W-1:0] coef_im_i,
  output qpge_pkg::amp_wr_t                 wr_o,
  output logic                              busy_o
);
  import qpge_pkg::*;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(16384);
  localparam logic signed [ACC_W-1:0] MAXV = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] MINV = ACC_W'(-32768);

  mac_ctl_t c2_r, c3_r;
  logic signed [PROD_W-1:0] prr_r, pii_r, pri_r, pir_r;
  logic signed [ACC_W-1:0]  acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0]  term_re, term_im;
  logic                     clip_re, clip_im;
  logic signed [AMP_W-1:0]  out_re, out_im;

  function automatic logic signed [AMP_W-1:0] rsat(input logic signed [ACC_W-1:0] a,
                                                   output logic clip);
    logic signed [ACC_W-1:0] q;
    if (a >= 0) begin
      q = (a + HALF) >>> 15;
    end else begin
      q = -((-a + HALF) >>> 15);
    end
    clip = (q > MAXV) || (q < MINV);
    if (q > MAXV) begin
      q = MAXV;
    end else if (q < MINV) begin
      q = MINV;
    end
    return q[AMP_W-1:0];
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.vld <= 1'b0;
    end else begin
      c2_r.vld <= ctl_i.vld;
    end
    c2_r.first <= ctl_i.first;
    c2_r.last  <= ctl_i.last;
    c2_r.dst   <= ctl_i.dst;
    prr_r <= coef_re_i * smp_re_i;
    pii_r <= coef_im_i * smp_im_i;
    pri_r <= coef_re_i * smp_im_i;
    pir_r <= coef_im_i * smp_re_i;
  end

  assign term_re = ACC_W'(prr_r) - ACC_W'(pii_r);
  assign term_im = ACC_W'(pri_r) + ACC_W'(pir_r);

  // accumulate stage; restart the sum on the first term of each output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r.vld <= 1'b0;
    end else begin
      c3_r.vld <= c2_r.vld && c2_r.last;
    end
    c3_r.first <= c2_r.first;
    c3_r.last  <= c2_r.last;
    c3_r.dst   <= c2_r.dst;
    if (c2_r.vld) begin
      acc_re_r <= c2_r.first ? term_re : acc_re_r + term_re;
      acc_im_r <= c2_r.first ? term_im : acc_im_r + term_im;
    end
  end

  always_comb begin
    out_re = rsat(acc_re_r, clip_re);
    out_im = rsat(acc_im_r, clip_im);
    wr_o.we   = c3_r.vld;
    wr_o.addr = c3_r.dst;
    wr_o.re   = out_re;
    wr_o.im   = out_im;
    wr_o.sat  = clip_re || clip_im;
  end

  assign busy_o = c2_r.vld || c3_r.vld;

endmodule

// ===== hw/rtl/qudit_pair_gate_engine_unit.sv =====
// Qudit pair gate engine: holds the joint state of two DIM-level qudits as DIM*DIM
// complex Q1.15 amplitudes and a loaded DIMxDIM unitary. A one-qudit gate (unitary,
// DFT, inverse DFT) runs DIM^3 terms (216 at DIM = 6) through the single complex
// MAC and the one read port of the amplitude memory; CZ runs DIM^2 terms. Amplitudes
// sit in a two-bank memory; a one-qudit gate reads one bank and writes the other,
// then swaps, while CZ updates its bank in place. No clearing pass after reset: a
// valid bit per amplitude makes unwritten entries read as zero.
// Depends on qpge_pkg, qpge_if and qpge_cmac.
module qudit_pair_gate_engine_unit #(
  parameter int DIM = 6
) (
  input logic      clk,
  input logic      rst_n,
  qpge_in_if.sink  in_ch,
  qpge_out_if.source out_ch
);
  import qpge_pkg::*;
  `include "qudit_pair_gate_engine_unit_assert.svh"

  localparam int NAMP = DIM * DIM;
  localparam int CW   = $clog2(DIM);
  localparam int AW   = $clog2(NAMP);
  localparam logic [CW-1:0] LAST  = CW'(DIM - 1);
  localparam logic [AW-1:0] DIM_A = AW'(DIM);

  // truncating quotient by shift and subtract; evaluated during elaboration only
  function automatic longint div_trunc(input longint num, input longint den);
    longint an, ad;
    longint unsigned un, ud, q, rem;
    an  = (num < 0) ? -num : num;
    ad  = (den < 0) ? -den : den;
    un  = an;
    ud  = ad;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], un[i]};
      q   = q << 1;
      if (rem >= ud) begin
        rem  = rem - ud;
        q[0] = 1'b1;
      end
    end
    an = q;
    return ((num < 0) != (den < 0)) ? -an : an;
  endfunction

  function automatic logic [DIM*COEF_W-1:0] build_tab(input bit want_sin, input bit is_cz);
    logic [DIM*COEF_W-1:0] tab;
    longint unsigned v, res, bt;
    longint r, x, c, s, tc, ts, num, d, val;
    int mm;
    tab = '0;
    v   = longint'(DIM) << 56;
    res = 0;
    bt  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (bt > v) bt = bt >> 2;
    end
    for (int i = 0; i < 32; i++) begin
      if (bt != 0) begin
        if (v >= res + bt) begin
          v   = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
    end
    r = longint'(res);
    for (int m = 0; m < DIM; m++) begin
      mm = (2 * m > DIM) ? m - DIM : m;
      x  = div_trunc(2 * PI28 * longint'(mm), longint'(DIM));
      c  = 0;
      s  = 0;
      tc = ONE28;
      ts = x;
      for (int n = 0; n < 20; n++) begin
        c  = c + tc;
        s  = s + ts;
        tc = div_trunc(div_trunc(div_trunc((0 - tc) * x, ONE28) * x, ONE28),
                       longint'((2 * n + 1) * (2 * n + 2)));
        ts = div_trunc(div_trunc(div_trunc((0 - ts) * x, ONE28) * x, ONE28),
                       longint'((2 * n + 2) * (2 * n + 3)));
      end
      num = want_sin ? s : c;
      if (is_cz) begin
        d = longint'(1) << 13;
      end else begin
        num = num * 32768;
        d   = r;
      end
      val = (num >= 0) ? div_trunc(num + (d >>> 1), d) : -div_trunc(-num + (d >>> 1), d);
      tab[m*COEF_W +: COEF_W] = val[COEF_W-1:0];
    end
    return tab;
  endfunction

  localparam logic [DIM*COEF_W-1:0] DFT_C = build_tab(1'b0, 1'b0);
  localparam logic [DIM*COEF_W-1:0] DFT_S = build_tab(1'b1, 1'b0);
  localparam logic [DIM*COEF_W-1:0] CZ_C  = build_tab(1'b0, 1'b1);
  localparam logic [DIM*COEF_W-1:0] CZ_S  = build_tab(1'b1, 1'b1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_RDWAIT = 4'b0010,
    ST_GATE   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, in_op;
  logic   side_r, bank_r, issue_done_r, rd_ok_r, sat_r, out_valid_r;
  logic [CW-1:0] j_r, p_r, k_r, m_r;
  logic [NAMP-1:0] amp_vld_r;
  logic signed [AMP_W-1:0] res_re_r, res_im_r, out_re_r, out_im_r;
  logic out_sat_r;

  logic in_fire, in_range, issuing, gate_done, finish_load, is_cz;
  logic [AW-1:0] in_addr, src_a, dst_a, uni_a;
  logic [CW:0]   m_sum;
  logic [CW-1:0] m_step;

  logic [2*AMP_W-1:0] amp_mem [2**(AW+1)];
  logic [2*AMP_W-1:0] uni_mem [NAMP];
  logic [2*AMP_W-1:0] amp_rd_r, uni_rd_r, amp_wdata;
  logic [AW:0]        amp_raddr, amp_waddr;
  logic               amp_we, uni_we;

  mac_ctl_t s1_ctl_r, s0_ctl;
  logic     s1_ent_r, s1_uni_r;
  logic signed [COEF_W-1:0] tab_re, tab_im, s1_tab_re_r, s1_tab_im_r;
  logic signed [COEF_W-1:0] coef_re, coef_im;
  logic signed [AMP_W-1:0]  smp_re, smp_im;
  amp_wr_t mac_wr;
  logic    mac_busy;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_op       = op_t'(in_ch.operation);
  assign in_range    = {1'b0, in_ch.index} < (IDX_W + 1)'(NAMP);
  assign in_addr     = in_ch.index[AW-1:0];

  // sweep addresses
  assign is_cz   = (op_r == OP_CZ);
  assign issuing = (state_r == ST_GATE) && !issue_done_r;
  always_comb begin
    uni_a = AW'(j_r) * DIM_A + AW'(k_r);
    if (is_cz) begin
      src_a = AW'(j_r) * DIM_A + AW'(p_r);
      dst_a = src_a;
    end else if (side_r) begin
      src_a = AW'(p_r) * DIM_A + AW'(k_r);
      dst_a = AW'(p_r) * DIM_A + AW'(j_r);
    end else begin
      src_a = AW'(k_r) * DIM_A + AW'(p_r);
      dst_a = AW'(j_r) * DIM_A + AW'(p_r);
    end
    s0_ctl.vld   = issuing;
    s0_ctl.first = is_cz || (k_r == '0);
    s0_ctl.last  = is_cz || (k_r == LAST);
    s0_ctl.dst   = IDX_W'(dst_a);
  end

  // phase power advances by j each inner step, wrapped mod DIM
  assign m_sum  = {1'b0, m_r} + {1'b0, j_r};
  assign m_step = (m_sum >= (CW + 1)'(DIM)) ? CW'(m_sum - (CW + 1)'(DIM)) : m_sum[CW-1:0];

  always_comb begin
    case (op_r)
      OP_IDFT: begin
        tab_re = DFT_C[int'(m_r)*COEF_W +: COEF_W];
        tab_im = -DFT_S[int'(m_r)*COEF_W +: COEF_W];
      end
      OP_CZ: begin
        tab_re = CZ_C[int'(m_r)*COEF_W +: COEF_W];
        tab_im = CZ_S[int'(m_r)*COEF_W +: COEF_W];
      end
      default: begin
        tab_re = DFT_C[int'(m_r)*COEF_W +: COEF_W];
        tab_im = DFT_S[int'(m_r)*COEF_W +: COEF_W];
      end
    endcase
  end

  // memory ports
  always_comb begin
    amp_raddr = (state_r == ST_IDLE) ? {bank_r, in_addr} : {bank_r, src_a};
    if (in_fire && in_op == OP_WR_AMP && in_range) begin
      amp_we    = 1'b1;
      amp_waddr = {bank_r, in_addr};
      amp_wdata = {in_ch.value_re, in_ch.value_im};
    end else begin
      amp_we    = mac_wr.we;
      amp_waddr = {is_cz ? bank_r : ~bank_r, mac_wr.addr[AW-1:0]};
      amp_wdata = {mac_wr.re, mac_wr.im};
    end
    uni_we = in_fire && in_op == OP_WR_UNI && in_range;
  end

  always_ff @(posedge clk) begin
    if (amp_we) amp_mem[amp_waddr] <= amp_wdata;
    amp_rd_r <= amp_mem[amp_raddr];
  end

  always_ff @(posedge clk) begin
    if (uni_we) uni_mem[in_addr] <= {in_ch.value_re, in_ch.value_im};
    uni_rd_r <= uni_mem[uni_a];
  end

  // operand stage aligned with the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.vld <= 1'b0;
    end else begin
      s1_ctl_r.vld <= s0_ctl.vld;
    end
    s1_ctl_r.first <= s0_ctl.first;
    s1_ctl_r.last  <= s0_ctl.last;
    s1_ctl_r.dst   <= s0_ctl.dst;
    s1_ent_r       <= amp_vld_r[src_a];
    s1_uni_r       <= (op_r == OP_APPLY);
    s1_tab_re_r    <= tab_re;
    s1_tab_im_r    <= tab_im;
  end

  assign smp_re  = s1_ent_r ? amp_rd_r[2*AMP_W-1:AMP_W] : '0;
  assign smp_im  = s1_ent_r ? amp_rd_r[AMP_W-1:0] : '0;
  assign coef_re = s1_uni_r ? {uni_rd_r[2*AMP_W-1], uni_rd_r[2*AMP_W-1:AMP_W]} : s1_tab_re_r;
  assign coef_im = s1_uni_r ? {uni_rd_r[AMP_W-1], uni_rd_r[AMP_W-1:0]} : s1_tab_im_r;

  qpge_cmac u_cmac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (s1_ctl_r),
    .smp_re_i  (smp_re),
    .smp_im_i  (smp_im),
    .coef_re_i (coef_re),
    .coef_im_i (coef_im),
    .wr_o      (mac_wr),
    .busy_o    (mac_busy)
  );

  assign gate_done   = (state_r == ST_GATE) && issue_done_r && !s1_ctl_r.vld && !mac_busy;
  assign finish_load = (state_r == ST_FINISH) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_APPLY, OP_DFT, OP_IDFT, OP_CZ: state_nxt = ST_GATE;
            OP_RD_AMP:                        state_nxt = ST_RDWAIT;
            default:                          state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_RDWAIT: state_nxt = ST_FINISH;
      ST_GATE:   if (gate_done) state_nxt = ST_FINISH;
      ST_FINISH: if (finish_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      bank_r       <= 1'b0;
      amp_vld_r    <= '0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
      sat_r        <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_fire) begin
        sat_r        <= 1'b0;
        issue_done_r <= 1'b0;
      end else if (mac_wr.we && mac_wr.sat) begin
        sat_r <= 1'b1;
      end
      if (amp_we && state_r == ST_IDLE) amp_vld_r[in_addr] <= 1'b1;
      // swap banks once the scratch bank holds every result
      if (gate_done && !is_cz) begin
        bank_r    <= ~bank_r;
        amp_vld_r <= '1;
      end
      if (issuing) begin
        if (is_cz) begin
          if (p_r == LAST) begin
            p_r <= '0;
            m_r <= '0;
            if (j_r == LAST) issue_done_r <= 1'b1;
            else j_r <= j_r + 1'b1;
          end else begin
            p_r <= p_r + 1'b1;
            m_r <= m_step;
          end
        end else begin
          if (k_r == LAST) begin
            k_r <= '0;
            m_r <= '0;
            if (p_r == LAST) begin
              p_r <= '0;
              if (j_r == LAST) issue_done_r <= 1'b1;
              else j_r <= j_r + 1'b1;
            end else begin
              p_r <= p_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
            m_r <= m_step;
          end
        end
      end else if (in_fire) begin
        j_r <= '0;
        p_r <= '0;
        k_r <= '0;
        m_r <= '0;
      end
      if (finish_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r     <= in_op;
      side_r   <= in_ch.side;
      rd_ok_r  <= in_range && amp_vld_r[in_addr];
      res_re_r <= '0;
      res_im_r <= '0;
    end
    if (state_r == ST_RDWAIT && rd_ok_r) begin
      res_re_r <= amp_rd_r[2*AMP_W-1:AMP_W];
      res_im_r <= amp_rd_r[AMP_W-1:0];
    end
    if (finish_load) begin
      out_re_r  <= res_re_r;
      out_im_r  <= res_im_r;
      out_sat_r <= sat_r;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.amp_re    = out_re_r;
  assign out_ch.amp_im    = out_im_r;
  assign out_ch.saturated = out_sat_r;

  `QPGE_NEVER(a_mac_wr_outside_gate, mac_wr.we && state_r != ST_GATE)
  `QPGE_CHECK(a_finish_drained, state_r == ST_FINISH |-> !s1_ctl_r.vld && !mac_busy)
  `QPGE_CHECK(a_bank_swap, (gate_done && !is_cz) |=> bank_r != $past(bank_r))
  `QPGE_CHECK(a_no_issue_outside_gate, s1_ctl_r.vld |-> state_r == ST_GATE)

endmodule

// ===== tb/qpge_gate_checker.sv =====
// Checker for the qudit pair gate engine: watches both channels, predicts each result
// from its own copy of the amplitude and unitary stores, and counts mismatches.
// Depends on qpge_pkg and the qpge_in_if / qpge_out_if interfaces.
`timescale 1ns / 1ps
module qpge_gate_checker (
  input  logic clk,
  input  logic rst_n,
  qpge_in_if   in_ch,
  qpge_out_if  out_ch,
  output int   fails,
  output int   pending
);
  import qpge_pkg::*;

  localparam int N    = 6;
  localparam int NAMP = N * N;

  typedef struct {
    logic signed [AMP_W-1:0] re;
    logic signed [AMP_W-1:0] im;
    logic                    sat;
  } amp_result_t;

  logic signed [AMP_W-1:0] st_re [NAMP];
  logic signed [AMP_W-1:0] st_im [NAMP];
  logic signed [AMP_W-1:0] uni_re[NAMP];
  logic signed [AMP_W-1:0] uni_im[NAMP];
  longint dft_c[N], dft_s[N], ph_c[N], ph_s[N];
  amp_result_t result_q[$];

  function automatic longint rdiv(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic logic signed [AMP_W-1:0] rnd_sat(longint acc, inout logic sat);
    longint v;
    v = rdiv(acc, 32768);
    if (v > 32767) begin
      sat = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      sat = 1'b1;
      return 16'sh8000;
    end
    return v[AMP_W-1:0];
  endfunction

  // Twiddles from an integer Taylor series in Q4.28, scaled by 1/sqrt(N) for the DFT.
  task automatic build_twiddles();
    longint unsigned v, res, bt;
    longint r, x, c, s, tc, ts;
    int mm;
    v   = longint'(N) << 56;
    res = 0;
    bt  = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    r = res;
    for (int m = 0; m < N; m++) begin
      mm = (2 * m > N) ? m - N : m;
      x  = (2 * PI28 * mm) / N;
      c = 0; s = 0; tc = ONE28; ts = x;
      for (int n = 0; n < 20; n++) begin
        c += tc;
        s += ts;
        tc = (0 - tc) * x / ONE28 * x / ONE28 / ((2 * n + 1) * (2 * n + 2));
        ts = (0 - ts) * x / ONE28 * x / ONE28 / ((2 * n + 2) * (2 * n + 3));
      end
      dft_c[m] = rdiv(c * 32768, r);
      dft_s[m] = rdiv(s * 32768, r);
      ph_c[m]  = rdiv(c, 64'sd1 << 13);
      ph_s[m]  = rdiv(s, 64'sd1 << 13);
    end
  endtask

  function automatic logic apply_gate(logic [OP_W-1:0] op, logic side);
    logic signed [AMP_W-1:0] nre[NAMP], nim[NAMP];
    longint ar, ai, cr, ci;
    int src, dst, m;
    logic sat;
    sat = 1'b0;
    for (int j = 0; j < N; j++) begin
      for (int p = 0; p < N; p++) begin
        ar = 0; ai = 0;
        for (int k = 0; k < N; k++) begin
          src = side ? p * N + k : k * N + p;
          m   = (j * k) % N;
          if (op == OP_APPLY) begin
            cr = uni_re[j * N + k];
            ci = uni_im[j * N + k];
          end else begin
            cr = dft_c[m];
            ci = (op == OP_DFT) ? dft_s[m] : -dft_s[m];
          end
          ar += cr * st_re[src] - ci * st_im[src];
          ai += cr * st_im[src] + ci * st_re[src];
        end
        dst = side ? p * N + j : j * N + p;
        nre[dst] = rnd_sat(ar, sat);
        nim[dst] = rnd_sat(ai, sat);
      end
    end
    st_re = nre;
    st_im = nim;
    return sat;
  endfunction

  function automatic logic apply_phase();
    longint re, im;
    int m;
    logic sat;
    sat = 1'b0;
    for (int a = 0; a < N; a++) begin
      for (int b = 0; b < N; b++) begin
        m  = (a * b) % N;
        re = st_re[a * N + b];
        im = st_im[a * N + b];
        st_re[a * N + b] = rnd_sat(re * ph_c[m] - im * ph_s[m], sat);
        st_im[a * N + b] = rnd_sat(re * ph_s[m] + im * ph_c[m], sat);
      end
    end
    return sat;
  endfunction

  function automatic amp_result_t predict(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                          logic side, logic signed [AMP_W-1:0] vr,
                                          logic signed [AMP_W-1:0] vi);
    amp_result_t e;
    e = '{re: '0, im: '0, sat: 1'b0};
    case (op)
      OP_WR_AMP: if (idx < NAMP) begin
        st_re[idx] = vr;
        st_im[idx] = vi;
      end
      OP_WR_UNI: if (idx < NAMP) begin
        uni_re[idx] = vr;
        uni_im[idx] = vi;
      end
      OP_APPLY, OP_DFT, OP_IDFT: e.sat = apply_gate(op, side);
      OP_CZ: e.sat = apply_phase();
      OP_RD_AMP: if (idx < NAMP) begin
        e.re = st_re[idx];
        e.im = st_im[idx];
      end
      default: ;
    endcase
    return e;
  endfunction

  initial begin
    build_twiddles();
    for (int i = 0; i < NAMP; i++) begin
      st_re[i] = '0; st_im[i] = '0; uni_re[i] = '0; uni_im[i] = '0;
    end
    fails = 0;
  end

  always @(posedge clk) begin
    amp_result_t e;
    if (rst_n && in_ch.valid && in_ch.ready)
      result_q.push_back(predict(in_ch.operation, in_ch.index, in_ch.side,
                                 in_ch.value_re, in_ch.value_im));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (result_q.size() == 0) begin
        if (fails < 10) $display("unexpected result transfer at %0t", $time);
        fails++;
      end else begin
        e = result_q.pop_front();
        if (out_ch.amp_re !== e.re || out_ch.amp_im !== e.im || out_ch.saturated !== e.sat)
        begin
          if (fails < 10)
            $display("mismatch at %0t: expected re %0d im %0d sat %0b, got re %0d im %0d sat %0b",
                     $time, e.re, e.im, e.sat, out_ch.amp_re, out_ch.amp_im,
                     out_ch.saturated);
          fails++;
        end
      end
    end
    pending = result_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// Top of the qudit pair gate engine testbench: clock, reset, stimulus and verdict.
// Depends on qpge_pkg, the channel interfaces, the engine and qpge_gate_checker.
`timescale 1ns / 1ps
module tb;
  import qpge_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int N_RANDOM  = 1400;
  localparam int TAIL      = 200;
  localparam int HOLD_LEN  = 600;
  localparam int WDOG_MAX  = 5000;

  logic clk, rst_n;
  int   fails, pending, sent, wdog;
  logic gaps_on, tail, hold_req, hold_done;
  logic uni_full;
  logic [35:0] uni_written;

  qpge_in_if  in_ch();
  qpge_out_if out_ch();

  qudit_pair_gate_engine_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  qpge_gate_checker chk (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
                         .fails(fails), .pending(pending));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx, logic side,
                      logic signed [AMP_W-1:0] vr, logic signed [AMP_W-1:0] vi);
    int gap;
    @(negedge clk);
    if (gaps_on && !tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.operation = op;
    in_ch.index     = idx;
    in_ch.side      = side;
    in_ch.value_re  = vr;
    in_ch.value_im  = vi;
    in_ch.valid     = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    sent++;
  endtask

  function automatic logic signed [AMP_W-1:0] rand_amp();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(0, 4095))) - 16'sd2048;
      2: return $signed(16'($urandom_range(0, 16383))) - 16'sd8192;
      default: return ($urandom_range(0, 1)) ? 16'sh7fff : 16'sh8000;
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off, none in the tail.
  initial begin
    int burst;
    burst = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_done = 1'b1;
      end else if (tail || !gaps_on) begin
        out_ch.ready = 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_ch.ready = 1'b0;
      end else if ($urandom_range(0, 6) == 0) begin
        burst = $urandom_range(1, 13) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Watchdog: cycles with no transfer on either channel.
  initial begin
    wdog = 0;
    forever begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [OP_W-1:0] op;
    logic [IDX_W-1:0] idx;
    int sel;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_WR_AMP;
    in_ch.index = '0;
    in_ch.side = 1'b0;
    in_ch.value_re = '0;
    in_ch.value_im = '0;
    gaps_on = 1'b0;
    tail = 1'b0;
    hold_req = 1'b0;
    sent = 0;
    uni_written = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, ignored indexes, unused code, every fixed gate.
    send(OP_RD_AMP, 6'd0, 1'b0, 16'sh0, 16'sh0);
    send(OP_WR_AMP, 6'd0, 1'b0, 16'sh7fff, 16'sh8000);
    send(OP_WR_AMP, 6'd35, 1'b0, 16'sh8000, 16'sh7fff);
    send(OP_WR_AMP, 6'd63, 1'b0, 16'sh1234, 16'sh4321);
    send(OP_WR_UNI, 6'd63, 1'b1, 16'sh1111, 16'sh2222);
    send(OP_RD_AMP, 6'd63, 1'b0, 16'sh0, 16'sh0);
    send(OP_RD_AMP, 6'd35, 1'b0, 16'sh0, 16'sh0);
    send(OP_UNUSED, 6'd0, 1'b1, 16'shffff, 16'shffff);
    send(OP_CZ, 6'd0, 1'b0, 16'sh0, 16'sh0);
    send(OP_DFT, 6'd0, 1'b0, 16'sh0, 16'sh0);
    send(OP_DFT, 6'd0, 1'b1, 16'sh0, 16'sh0);
    send(OP_IDFT, 6'd0, 1'b0, 16'sh0, 16'sh0);
    send(OP_IDFT, 6'd0, 1'b1, 16'sh0, 16'sh0);
    send(OP_WR_AMP, 6'd7, 1'b0, 16'sh0400, 16'shfc00);
    send(OP_DFT, 6'd0, 1'b0, 16'sh0, 16'sh0);
    send(OP_RD_AMP, 6'd7, 1'b0, 16'sh0, 16'sh0);
    send(OP_RD_AMP, 6'd1, 1'b0, 16'sh0, 16'sh0);

    gaps_on = 1'b1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 300) hold_req = 1'b1;
      if (i == N_RANDOM - TAIL) tail = 1'b1;
      uni_full = &uni_written;
      sel = $urandom_range(0, 99);
      // Apply the loaded unitary only once every entry has been written.
      if (!uni_full) begin
        idx = IDX_W'($urandom_range(0, 35));
        while (uni_written[idx]) idx = IDX_W'((int'(idx) + 1) % 36);
        uni_written[idx] = 1'b1;
        send(OP_WR_UNI, idx, 1'($urandom_range(0, 1)), rand_amp(), rand_amp());
        continue;
      end
      if (sel < 30) op = OP_WR_AMP;
      else if (sel < 40) op = OP_WR_UNI;
      else if (sel < 48) op = OP_APPLY;
      else if (sel < 56) op = OP_DFT;
      else if (sel < 64) op = OP_IDFT;
      else if (sel < 69) op = OP_CZ;
      else if (sel < 97) op = OP_RD_AMP;
      else op = OP_UNUSED;
      idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom_range(36, 63))
                                        : IDX_W'($urandom_range(0, 35));
      send(op, idx, 1'($urandom_range(0, 1)), rand_amp(), rand_amp());
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
